FILE: hw/rtl/aled_pkg.sv
// Shared types, constants and the default color table for the addressable
// LED bit serializer. No dependencies; every file but aled_out_if uses this one.
package aled_pkg;

  localparam int unsigned DEFAULT_PIXEL_COUNT = 12;
  localparam int unsigned BITS_PER_PIXEL      = 24;
  localparam int unsigned INDEX_W             = 4;
  // only this many entries are reachable through the pixel index field
  localparam int unsigned STORE_MAX           = 2 ** INDEX_W;
  localparam int unsigned COLOR_W             = 8;
  localparam int unsigned CFG_INDEX_W         = 3;
  localparam int unsigned CFG_DATA_W          = 8;
  localparam int unsigned SLOT_W              = 7;

  localparam logic [7:0] ZERO_CODE_RST  = 8'd12;
  localparam logic [7:0] ONE_CODE_RST   = 8'd30;
  localparam logic [5:0] LEAD_BLANK_RST = 6'd10;
  localparam logic [3:0] TRAIL_BLANK_RST = 4'd2;
  localparam logic [5:0] GAP_SLOTS_RST  = 6'd12;

  typedef enum logic [1:0] {
    OP_WRITE_COLOR = 2'd0,
    OP_WRITE_ON    = 2'd1,
    OP_START       = 2'd2,
    OP_TICK        = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_LEAD  = 2'd1,
    PH_DATA  = 2'd2,
    PH_TRAIL = 2'd3
  } phase_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ZERO_CODE   = 3'd0,
    REG_ONE_CODE    = 3'd1,
    REG_LEAD_BLANK  = 3'd2,
    REG_TRAIL_BLANK = 3'd3,
    REG_GAP_SLOTS   = 3'd4
  } cfg_reg_t;

  // colors packed as green, red, blue from high to low
  function automatic logic [23:0] default_color(input int unsigned idx);
    logic [23:0] c;
    unique case (idx)
      0:       c = 24'hFF0000;
      1:       c = 24'h0000FF;
      2:       c = 24'h0000FF;
      3:       c = 24'h00FFFF;
      4:       c = 24'h00FF00;
      5:       c = 24'h80FF00;
      6:       c = 24'hFFFF00;
      7:       c = 24'hFF0000;
      8:       c = 24'hFF0080;
      9:       c = 24'h0000FF;
      10:      c = 24'h0080FF;
      11:      c = 24'h00FFFF;
      default: c = 24'h000000;
    endcase
    return c;
  endfunction

endpackage

FILE: hw/rtl/aled_in_if.sv
// Input channel of the LED serializer: valid/ready plus one command item.
// Depends on aled_pkg for field types.
interface aled_in_if;
  logic                                valid;
  logic                                ready;
  aled_pkg::op_t                       operation;
  logic [aled_pkg::INDEX_W-1:0]        pixel_index;
  logic [aled_pkg::COLOR_W-1:0]        red;
  logic [aled_pkg::COLOR_W-1:0]        green;
  logic [aled_pkg::COLOR_W-1:0]        blue;
  logic                                on_flag;

  modport source (output valid, operation, pixel_index, red, green, blue, on_flag,
                  input ready);
  modport sink   (input valid, operation, pixel_index, red, green, blue, on_flag,
                  output ready);
endinterface

FILE: hw/rtl/aled_out_if.sv
// Result channel of the LED serializer: valid/ready plus one duty slot.
// No dependencies.
interface aled_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] duty_code;
  logic       frame_last;

  modport source (output valid, duty_code, frame_last, input ready);
  modport sink   (input valid, duty_code, frame_last, output ready);
endinterface

FILE: hw/rtl/addressable_led_bit_serializer.sv
// Addressable LED bit serializer: pixel store, frame sequencer, output register.
// Depends on aled_pkg, aled_in_if and aled_out_if.
//
// Usage:
//   in_ch carries commands: write a pixel color, write a pixel on flag,
//   start a frame, or tick one PWM slot. Writes to an index at or beyond
//   PIXEL_COUNT are dropped. Each tick during a frame yields one transfer on
//   out_ch: the duty code for that slot, with frame_last on the final slot.
//   Writes, starts and idle ticks yield nothing.
//   cfg_we/cfg_index/cfg_wdata write the five timing and code registers;
//   write them only while out_ch is empty; a change applies from the next tick.
// Timing:
//   One command is taken per cycle. A tick's result appears on out_ch in the
//   cycle after its transfer. The single output register sets
//   the rate: in_ch.ready stays high while that register is empty or being
//   drained, so a receiver that takes every cycle sees one slot per cycle.
//   When the receiver stalls, the result holds and in_ch.ready drops.
// Reset:
//   rst_n (synchronous, active low) loads the default colors, sets every
//   pixel on, returns the sequencer to idle and restores register defaults.
module addressable_led_bit_serializer #(
  parameter int unsigned PIXEL_COUNT = aled_pkg::DEFAULT_PIXEL_COUNT
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  aled_in_if.sink                               in_ch,
  aled_out_if.source                            out_ch,
  input  logic                                  cfg_we,
  input  logic [aled_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [aled_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
  import aled_pkg::*;

  localparam int unsigned STORE_D  = (PIXEL_COUNT < STORE_MAX) ? PIXEL_COUNT : STORE_MAX;
  localparam int unsigned STORE_AW = (STORE_D > 1) ? $clog2(STORE_D) : 1;
  localparam int unsigned PC_MAX   = (PIXEL_COUNT > 64) ? PIXEL_COUNT : 64;
  localparam int unsigned PCW      = $clog2(PC_MAX + 1);

  // configuration
  logic [7:0] zero_code_r, one_code_r;
  logic [5:0] lead_blank_r, gap_slots_r;
  logic [3:0] trail_blank_r;

  // pixel store
  logic [23:0] colors_r [STORE_D];
  logic        on_r     [STORE_D];

  // sequencer
  phase_t            phase_r, phase_nxt;
  logic [PCW-1:0]    pixel_r, pixel_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;

  // output register
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] duty_r, duty_nxt;
  logic       last_r, last_nxt;

  logic           accept;
  logic           produce;
  logic           wr_ok;
  logic [SLOT_W:0] period;
  logic [SLOT_W:0] slot_inc;
  logic [PCW:0]   pixel_inc;
  logic           period_end;
  logic           in_store;
  logic [23:0]    cur_color;
  logic           cur_on;
  logic [4:0]     bit_sel;
  logic           cur_bit;

  assign in_ch.ready       = !out_valid_r || out_ch.ready;
  assign accept            = in_ch.valid && in_ch.ready;
  assign produce           = accept && (in_ch.operation == OP_TICK) && (phase_r != PH_IDLE);
  assign wr_ok             = ({{(PCW-INDEX_W){1'b0}}, in_ch.pixel_index} < PCW'(PIXEL_COUNT));

  assign out_ch.valid      = out_valid_r;
  assign out_ch.duty_code  = duty_r;
  assign out_ch.frame_last = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_code_r   <= ZERO_CODE_RST;
      one_code_r    <= ONE_CODE_RST;
      lead_blank_r  <= LEAD_BLANK_RST;
      trail_blank_r <= TRAIL_BLANK_RST;
      gap_slots_r   <= GAP_SLOTS_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ZERO_CODE:   zero_code_r   <= cfg_wdata;
        REG_ONE_CODE:    one_code_r    <= cfg_wdata;
        REG_LEAD_BLANK:  lead_blank_r  <= cfg_wdata[5:0];
        REG_TRAIL_BLANK: trail_blank_r <= cfg_wdata[3:0];
        REG_GAP_SLOTS:   gap_slots_r   <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STORE_D; i++) begin
        colors_r[i] <= default_color(i);
        on_r[i]     <= 1'b1;
      end
    end else if (accept && wr_ok) begin
      if (in_ch.operation == OP_WRITE_COLOR) begin
        colors_r[in_ch.pixel_index[STORE_AW-1:0]] <= {in_ch.green, in_ch.red, in_ch.blue};
      end
      if (in_ch.operation == OP_WRITE_ON) begin
        on_r[in_ch.pixel_index[STORE_AW-1:0]] <= in_ch.on_flag;
      end
    end
  end

  // pixels past the writable store are always black
  assign in_store  = (pixel_r < PCW'(STORE_D));
  assign cur_color = in_store ? colors_r[pixel_r[STORE_AW-1:0]] : 24'h000000;
  assign cur_on    = in_store ? on_r[pixel_r[STORE_AW-1:0]] : 1'b0;
  assign bit_sel   = 5'(5'd23 - slot_r[4:0]);
  assign cur_bit   = cur_on && cur_color[bit_sel];

  assign period     = (SLOT_W+1)'(BITS_PER_PIXEL) + {{(SLOT_W+1-6){1'b0}}, gap_slots_r};
  assign slot_inc   = {1'b0, slot_r} + 1'b1;
  assign pixel_inc  = {1'b0, pixel_r} + 1'b1;
  assign period_end = (slot_inc >= period);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      pixel_r     <= '0;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      pixel_r     <= pixel_nxt;
      slot_r      <= slot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    duty_r <= duty_nxt;
    last_r <= last_nxt;
  end

  always_comb begin
    phase_nxt     = phase_r;
    pixel_nxt     = pixel_r;
    slot_nxt      = slot_r;
    out_valid_nxt = out_valid_r;
    duty_nxt      = duty_r;
    last_nxt      = last_r;

    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (accept && in_ch.operation == OP_START) begin
      pixel_nxt = '0;
      slot_nxt  = '0;
      phase_nxt = (lead_blank_r == '0) ? PH_DATA : PH_LEAD;
    end else if (produce) begin
      out_valid_nxt = 1'b1;
      duty_nxt      = 8'd0;
      last_nxt      = 1'b0;

      if (phase_r == PH_DATA && slot_r < SLOT_W'(BITS_PER_PIXEL)) begin
        duty_nxt = cur_bit ? one_code_r : zero_code_r;
      end

      if (period_end) begin
        if (phase_r == PH_TRAIL && pixel_inc >= {{(PCW+1-4){1'b0}}, trail_blank_r}) begin
          last_nxt = 1'b1;
        end
        if (phase_r == PH_DATA && trail_blank_r == '0 &&
            pixel_inc >= (PCW+1)'(PIXEL_COUNT)) begin
          last_nxt = 1'b1;
        end
      end

      slot_nxt = slot_inc[SLOT_W-1:0];
      if (period_end) begin
        slot_nxt  = '0;
        pixel_nxt = pixel_inc[PCW-1:0];
        unique case (phase_r)
          PH_LEAD: begin
            if (pixel_inc >= {{(PCW+1-6){1'b0}}, lead_blank_r}) begin
              phase_nxt = PH_DATA;
              pixel_nxt = '0;
            end
          end
          PH_DATA: begin
            if (pixel_inc >= (PCW+1)'(PIXEL_COUNT)) begin
              pixel_nxt = '0;
              phase_nxt = (trail_blank_r == '0) ? PH_IDLE : PH_TRAIL;
            end
          end
          PH_TRAIL: begin
            if (pixel_inc >= {{(PCW+1-4){1'b0}}, trail_blank_r}) begin
              pixel_nxt = '0;
              phase_nxt = PH_IDLE;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // a slot flagged as last always closes the frame
  a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    produce && last_nxt |=> phase_r == PH_IDLE)
    else $error("frame_last slot did not return the sequencer to idle");

  a_data_pixel_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> pixel_r < PCW'(PIXEL_COUNT))
    else $error("data phase pixel counter past the pixel count");

  a_no_result_from_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.operation != OP_TICK && !out_valid_r |=> !out_valid_r)
    else $error("non-tick command produced a result");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r < SLOT_W'(BITS_PER_PIXEL + 63))
    else $error("slot counter past the longest pixel period");

endmodule

FILE: tb/addressable_led_bit_serializer_test.sv
`timescale 1ns / 1ps
// Self-checking test of addressable_led_bit_serializer: a directed table, then random
// phases under changing idling; slots checked against table values or a predictor.
// Depends on aled_pkg, aled_in_if, aled_out_if and the serializer RTL.
module addressable_led_bit_serializer_test;
  import aled_pkg::*;

  localparam int unsigned PIX           = DEFAULT_PIXEL_COUNT;
  localparam int unsigned NUM_REGS      = 5;
  localparam int unsigned NUM_PHASES    = 7;
  localparam int unsigned PHASE_ITEMS   = 255;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned DRAIN_LIMIT   = 20000;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct packed {
    logic [7:0] duty_code;
    logic       frame_last;
  } slot_t;

  // one table row: either a register write or a command transfer
  typedef struct packed {
    bit           is_cfg;
    cfg_reg_t     cfg_sel;
    logic [7:0]   reg_val;
    op_t          operation;
    logic [3:0]   pixel_index;
    logic [7:0]   red;
    logic [7:0]   green;
    logic [7:0]   blue;
    logic         on_flag;
    bit           typed;
    slot_t        typed_slot;
  } row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  aled_in_if  in_ch ();
  aled_out_if out_ch ();

  addressable_led_bit_serializer #(
    .PIXEL_COUNT(PIX)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // power-up colors, green/red/blue from high to low
  logic [23:0] boot_colors [PIX] = '{
    24'hFF0000, 24'h0000FF, 24'h0000FF, 24'h00FFFF,
    24'h00FF00, 24'h80FF00, 24'hFFFF00, 24'hFF0000,
    24'hFF0080, 24'h0000FF, 24'h0080FF, 24'h00FFFF
  };

  // zero code, one code, lead blanks, trail blanks, gap slots
  logic [7:0] phase_cfg [NUM_PHASES][NUM_REGS] = '{
    '{8'd0,   8'd255, 8'd0,  8'd0,  8'd0},
    '{8'd255, 8'd0,   8'd1,  8'd1,  8'd1},
    '{8'd12,  8'd30,  8'd0,  8'd3,  8'd2},
    '{8'd255, 8'd255, 8'd63, 8'd15, 8'd63},
    '{8'd7,   8'd200, 8'd1,  8'd0,  8'd5},
    '{8'd0,   8'd0,   8'd2,  8'd15, 8'd0},
    '{ZERO_CODE_RST, ONE_CODE_RST, 8'(LEAD_BLANK_RST), 8'(TRAIL_BLANK_RST),
      8'(GAP_SLOTS_RST)}
  };

  // predictor state
  logic [23:0]  color_store [PIX];
  logic         lit_store   [PIX];
  phase_t       seq_phase;
  int unsigned  pixel_cnt;
  int unsigned  slot_cnt;
  logic [7:0]   zero_duty;
  logic [7:0]   one_duty;
  logic [5:0]   lead_periods;
  logic [3:0]   trail_periods;
  logic [5:0]   gap_len;

  slot_t        slots_due [$];
  int           fail_count = 0;
  idle_mode_t   idle_mode  = IDLE_NONE;
  bit           hold_req   = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic void reset_predictor();
    for (int i = 0; i < PIX; i++) begin
      color_store[i] = boot_colors[i];
      lit_store[i]   = 1'b1;
    end
    seq_phase     = PH_IDLE;
    pixel_cnt     = 0;
    slot_cnt      = 0;
    zero_duty     = ZERO_CODE_RST;
    one_duty      = ONE_CODE_RST;
    lead_periods  = LEAD_BLANK_RST;
    trail_periods = TRAIL_BLANK_RST;
    gap_len       = GAP_SLOTS_RST;
  endfunction

  function automatic void apply_cfg(input cfg_reg_t sel, input logic [7:0] val);
    case (sel)
      REG_ZERO_CODE:   zero_duty     = val;
      REG_ONE_CODE:    one_duty      = val;
      REG_LEAD_BLANK:  lead_periods  = val[5:0];
      REG_TRAIL_BLANK: trail_periods = val[3:0];
      REG_GAP_SLOTS:   gap_len       = val[5:0];
      default: ;
    endcase
  endfunction

  // Advance the sequencer by one command; returns 1 when a slot goes out.
  function automatic bit predict_slot(input row_t c, output slot_t s);
    int unsigned period;
    bit          period_end;
    bit          data_bit;
    s = '0;
    case (c.operation)
      OP_WRITE_COLOR: begin
        if (c.pixel_index < PIX) color_store[c.pixel_index] = {c.green, c.red, c.blue};
        return 1'b0;
      end
      OP_WRITE_ON: begin
        if (c.pixel_index < PIX) lit_store[c.pixel_index] = c.on_flag;
        return 1'b0;
      end
      OP_START: begin
        pixel_cnt = 0;
        slot_cnt  = 0;
        seq_phase = (lead_periods == 0) ? PH_DATA : PH_LEAD;
        return 1'b0;
      end
      default: ;
    endcase
    if (seq_phase == PH_IDLE) return 1'b0;

    period     = BITS_PER_PIXEL + gap_len;
    period_end = (slot_cnt + 1 >= period);

    if (seq_phase == PH_DATA && slot_cnt < BITS_PER_PIXEL && pixel_cnt < PIX) begin
      data_bit = lit_store[pixel_cnt] ? color_store[pixel_cnt][23 - slot_cnt] : 1'b0;
      s.duty_code = data_bit ? one_duty : zero_duty;
    end
    if (period_end) begin
      if (seq_phase == PH_TRAIL && pixel_cnt + 1 >= trail_periods) s.frame_last = 1'b1;
      if (seq_phase == PH_DATA && trail_periods == 0 && pixel_cnt + 1 >= PIX)
        s.frame_last = 1'b1;
    end

    slot_cnt++;
    if (period_end) begin
      slot_cnt = 0;
      pixel_cnt++;
      case (seq_phase)
        PH_LEAD: begin
          if (pixel_cnt >= lead_periods) begin
            seq_phase = PH_DATA;
            pixel_cnt = 0;
          end
        end
        PH_DATA: begin
          if (pixel_cnt >= PIX) begin
            pixel_cnt = 0;
            seq_phase = (trail_periods == 0) ? PH_IDLE : PH_TRAIL;
          end
        end
        default: begin
          if (pixel_cnt >= trail_periods) begin
            pixel_cnt = 0;
            seq_phase = PH_IDLE;
          end
        end
      endcase
    end
    return 1'b1;
  endfunction

  function automatic int unsigned idle_pct(input bit sender_side);
    case (idle_mode)
      IDLE_SENDER:   return sender_side ? 86 : 0;
      IDLE_RECEIVER: return sender_side ? 0 : 86;
      IDLE_BOTH:     return 6;
      default:       return 0;
    endcase
  endfunction

  function automatic row_t cmd_row(input op_t op, input logic [3:0] idx,
                                   input logic [7:0] r, input logic [7:0] g,
                                   input logic [7:0] b, input logic on);
    row_t c;
    c             = '0;
    c.cfg_sel     = REG_ZERO_CODE;
    c.operation   = op;
    c.pixel_index = idx;
    c.red         = r;
    c.green       = g;
    c.blue        = b;
    c.on_flag     = on;
    return c;
  endfunction

  function automatic row_t tick_row(input logic [7:0] duty, input logic last);
    row_t c;
    c = cmd_row(OP_TICK, 4'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                1'($urandom));
    c.typed                 = 1'b1;
    c.typed_slot.duty_code  = duty;
    c.typed_slot.frame_last = last;
    return c;
  endfunction

  function automatic row_t cfg_row(input cfg_reg_t sel, input logic [7:0] val);
    row_t c;
    c         = cmd_row(OP_TICK, '0, '0, '0, '0, 1'b0);
    c.is_cfg  = 1'b1;
    c.cfg_sel = sel;
    c.reg_val = val;
    return c;
  endfunction

  // Mostly well-formed traffic: starts when idle, ticks with sparse live writes.
  function automatic row_t random_row();
    row_t        c;
    int unsigned pick;
    pick = $urandom_range(99);
    c = cmd_row(OP_TICK, 4'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                $urandom_range(3) != 0);
    if (seq_phase == PH_IDLE) begin
      if (pick < 60)      c.operation = OP_START;
      else if (pick < 85) c.operation = OP_WRITE_COLOR;
      else if (pick < 92) c.operation = OP_WRITE_ON;
    end else begin
      if (pick < 1)       c.operation = OP_START;
      else if (pick < 9)  c.operation = OP_WRITE_COLOR;
      else if (pick < 14) c.operation = OP_WRITE_ON;
    end
    if (c.operation == OP_WRITE_COLOR || c.operation == OP_WRITE_ON)
      c.pixel_index = ($urandom_range(9) == 0) ? 4'($urandom_range(15, PIX))
                                                : 4'($urandom_range(PIX - 1));
    return c;
  endfunction

  task automatic wait_drained();
    while (slots_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_row(input row_t c);
    slot_t s;
    if (c.is_cfg) begin
      // registers change only with the output side drained
      in_ch.valid <= 1'b0;
      wait_drained();
      cfg_we    <= 1'b1;
      cfg_index <= c.cfg_sel;
      cfg_wdata <= c.reg_val;
      @(posedge clk);
      apply_cfg(c.cfg_sel, c.reg_val);
      cfg_we <= 1'b0;
      return;
    end
    if ($urandom_range(99) < idle_pct(1'b1)) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct(1'b1));
    end
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= c.operation;
    in_ch.pixel_index <= c.pixel_index;
    in_ch.red         <= c.red;
    in_ch.green       <= c.green;
    in_ch.blue        <= c.blue;
    in_ch.on_flag     <= c.on_flag;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    if (predict_slot(c, s)) slots_due.push_back(c.typed ? c.typed_slot : s);
  endtask

  initial begin : result_side
    slot_t       want;
    int unsigned hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (slots_due.size() == 0) begin
          $error("unexpected slot: duty_code %0d, frame_last %0d",
                 out_ch.duty_code, out_ch.frame_last);
          fail_count++;
        end else begin
          want = slots_due.pop_front();
          if (out_ch.duty_code !== want.duty_code) begin
            $error("duty_code: expected %0d, got %0d", want.duty_code, out_ch.duty_code);
            fail_count++;
          end
          if (out_ch.frame_last !== want.frame_last) begin
            $error("frame_last: expected %0d, got %0d", want.frame_last, out_ch.frame_last);
            fail_count++;
          end
        end
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= idle_pct(1'b0));
      end
      @(posedge clk);
    end
  end

  initial begin : stimulus
    row_t        dir_tab [$];
    row_t        c;
    int unsigned taken;
    int unsigned waited;
    bit          countable;

    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= REG_ZERO_CODE;
    cfg_wdata         <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.operation   <= OP_TICK;
    in_ch.pixel_index <= '0;
    in_ch.red         <= '0;
    in_ch.green       <= '0;
    in_ch.blue        <= '0;
    in_ch.on_flag     <= 1'b0;
    reset_predictor();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // idle tick, out-of-range writes, lead blanks at power-up settings
    dir_tab.push_back(cmd_row(OP_TICK, 4'd0, 8'd0, 8'd0, 8'd0, 1'b0));
    dir_tab.push_back(cmd_row(OP_WRITE_COLOR, 4'd15, 8'hFF, 8'hFF, 8'hFF, 1'b1));
    dir_tab.push_back(cmd_row(OP_WRITE_ON, 4'd12, 8'd0, 8'd0, 8'd0, 1'b0));
    dir_tab.push_back(cmd_row(OP_WRITE_ON, 4'd15, 8'hFF, 8'hFF, 8'hFF, 1'b1));
    dir_tab.push_back(cmd_row(OP_START, 4'd0, 8'd0, 8'd0, 8'd0, 1'b0));
    dir_tab.push_back(tick_row(8'd0, 1'b0));
    dir_tab.push_back(tick_row(8'd0, 1'b0));
    // extreme codes, no lead, trail or gap
    dir_tab.push_back(cfg_row(REG_ZERO_CODE, 8'd0));
    dir_tab.push_back(cfg_row(REG_ONE_CODE, 8'd255));
    dir_tab.push_back(cfg_row(REG_LEAD_BLANK, 8'd0));
    dir_tab.push_back(cfg_row(REG_TRAIL_BLANK, 8'd0));
    dir_tab.push_back(cfg_row(REG_GAP_SLOTS, 8'd0));
    dir_tab.push_back(cmd_row(OP_START, 4'd0, 8'd0, 8'd0, 8'd0, 1'b0));
    dir_tab.push_back(tick_row(8'd255, 1'b0));
    // off pixel goes out black
    dir_tab.push_back(cmd_row(OP_WRITE_ON, 4'd0, 8'd0, 8'd0, 8'd0, 1'b0));
    dir_tab.push_back(tick_row(8'd0, 1'b0));
    dir_tab.push_back(cmd_row(OP_WRITE_ON, 4'd0, 8'd0, 8'd0, 8'd0, 1'b1));
    dir_tab.push_back(cmd_row(OP_WRITE_COLOR, 4'd0, 8'h00, 8'hAA, 8'hFF, 1'b0));
    dir_tab.push_back(cmd_row(OP_TICK, 4'd15, 8'hFF, 8'hFF, 8'hFF, 1'b1));
    dir_tab.push_back(cmd_row(OP_WRITE_COLOR, 4'd11, 8'hFF, 8'hFF, 8'hFF, 1'b1));
    // restart mid-frame, then swap codes mid-frame
    dir_tab.push_back(cmd_row(OP_START, 4'd0, 8'd0, 8'd0, 8'd0, 1'b0));
    dir_tab.push_back(cmd_row(OP_TICK, 4'd0, 8'd0, 8'd0, 8'd0, 1'b0));
    dir_tab.push_back(cfg_row(REG_ZERO_CODE, 8'd255));
    dir_tab.push_back(cfg_row(REG_ONE_CODE, 8'd0));
    dir_tab.push_back(cmd_row(OP_TICK, 4'd0, 8'd0, 8'd0, 8'd0, 1'b0));

    foreach (dir_tab[i]) send_row(dir_tab[i]);

    for (int p = 0; p < NUM_PHASES; p++) begin
      for (int r = 0; r < NUM_REGS; r++)
        send_row(cfg_row(cfg_reg_t'(r), phase_cfg[p][r]));
      idle_mode = idle_mode_t'(p % 4);
      // starve the output for a long stretch while commands keep coming
      if (p == 0) hold_req = 1'b1;
      taken = 0;
      while (taken < PHASE_ITEMS) begin
        if (p == 2 && taken == PHASE_ITEMS / 2) begin
          in_ch.valid <= 1'b0;
          wait_drained();
        end
        c = random_row();
        countable = !((c.operation == OP_TICK && seq_phase == PH_IDLE) ||
                      (c.operation != OP_TICK && c.operation != OP_START &&
                       c.pixel_index >= PIX));
        send_row(c);
        if (countable) taken++;
      end
    end

    in_ch.valid <= 1'b0;
    idle_mode   = IDLE_NONE;
    waited      = 0;
    while (slots_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (slots_due.size() != 0) begin
      $error("%0d expected slots never arrived", slots_due.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
